@@ rtl/abta_pkg.sv @@
// ----------------------------------------------------------------------------
// Address binding table package
// Shared types, codes and constants of the address binding table with aging.
// ----------------------------------------------------------------------------
package abta_pkg;

   localparam int DEFAULT_ENTRIES    = 16;
   localparam int KEY_W              = 64;
   localparam int LIFE_W             = 16;
   localparam int COUNT_W            = 22;
   localparam int STALE_W            = 17;
   localparam int SLOT_W             = 4;
   localparam int STATUS_W           = 3;
   localparam int KIND_W             = 2;
   localparam int CMD_W              = 3;
   localparam int MAX_REPORTS        = 16;
   localparam int REPORT_CNT_W       = $clog2(MAX_REPORTS + 1);
   localparam int SECONDS_PER_MINUTE = 60;
   localparam logic [STALE_W-1:0] STALE_RESET = STALE_W'(86400);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD            = 3'd0,
      CMD_LOOKUP         = 3'd1,
      CMD_REMOVE         = 3'd2,
      CMD_MARK_TENTATIVE = 3'd3,
      CMD_MARK_REACHABLE = 3'd4,
      CMD_MARK_STALE     = 3'd5,
      CMD_TICK           = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_EXPIRED   = 3'd4
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TENTATIVE = 2'd0,
      KIND_REACHABLE = 2'd1,
      KIND_STALE     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY,
      FSM_FLUSH
   } fsm_type;

   typedef struct packed {
      kind_type           kind;
      logic               timer_on;
      logic [COUNT_W-1:0] countdown;
   } meta_type;

   typedef struct packed {
      logic     match;
      logic     meta_we;
      meta_type meta;
      logic     clear_valid;
      logic     report;
   } eval_type;

   typedef struct packed {
      status_type        status;
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic              last;
   } rsp_type;

endpackage

@@ rtl/abta_store.sv @@
// ----------------------------------------------------------------------------
// Address binding table entry store
// Key and entry state memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module abta_store #(
   parameter int ENTRIES = abta_pkg::DEFAULT_ENTRIES
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [2*abta_pkg::KEY_W-1:0] rd_key,
   output abta_pkg::meta_type         rd_meta,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic                       key_we,
   input  logic [2*abta_pkg::KEY_W-1:0] wr_key,
   input  logic                       meta_we,
   input  abta_pkg::meta_type         wr_meta
);
   import abta_pkg::*;

   logic [2*KEY_W-1:0] key_mem [ENTRIES];
   meta_type           meta_mem [ENTRIES];
   logic [2*KEY_W-1:0] rd_key_ff;
   meta_type           rd_meta_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (meta_we) begin
         meta_mem[wr_addr] <= wr_meta;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_meta_ff <= meta_mem[rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_meta = rd_meta_ff;

endmodule

@@ rtl/abta_eval.sv @@
// ----------------------------------------------------------------------------
// Address binding table entry unit
// Shared key compare and timer ageing step applied to one entry per cycle.
// ----------------------------------------------------------------------------
module abta_eval (
   input  logic                         is_tick,
   input  logic                         entry_valid,
   input  logic [2*abta_pkg::KEY_W-1:0] search_key,
   input  logic [2*abta_pkg::KEY_W-1:0] entry_key,
   input  abta_pkg::meta_type           entry_meta,
   input  logic [abta_pkg::STALE_W-1:0] stale_seconds,
   input  logic                         reports_full,
   output abta_pkg::eval_type           result
);
   import abta_pkg::*;

   logic aging;

   assign aging = is_tick && entry_valid && entry_meta.timer_on;

   always_comb begin
      result             = '0;
      result.meta        = entry_meta;
      result.match       = entry_valid && (entry_key == search_key);
      if (aging) begin
         result.meta_we = 1'b1;
         if (entry_meta.countdown > COUNT_W'(1)) begin
            result.meta.countdown = entry_meta.countdown - COUNT_W'(1);
         end else if (entry_meta.kind == KIND_REACHABLE) begin
            result.meta.kind      = KIND_STALE;
            result.meta.countdown = COUNT_W'(stale_seconds);
         end else if (entry_meta.kind == KIND_STALE) begin
            if (reports_full) begin
               result.meta.countdown = '0;
            end else begin
               result.meta.timer_on = 1'b0;
               result.clear_valid   = 1'b1;
               result.report        = 1'b1;
            end
         end else begin
            result.meta.timer_on = 1'b0;
         end
      end
   end

endmodule

@@ rtl/address_binding_table_aging.sv @@
// ----------------------------------------------------------------------------
// Address binding table with aging
// A table of TABLE_ENTRIES entries keyed by a 128-bit address. Every command
// except the unused code scans the whole table through one shared compare and
// ageing unit, one entry per cycle from the single read port of the entry
// memory while no expiry report waits on a stalled receiver. Each request
// holds req_stall high until its last reply, if any, is loaded into the reply
// register, so the block takes no new request before it is through with the
// last one. The unused command code is accepted and gives no reply. Expiry
// reports of a tick leave in slot order as they are found. Entry valid bits
// are flip-flops cleared by reset, so there is no clearing pass.
// ----------------------------------------------------------------------------
module address_binding_table_aging #(
   parameter int TABLE_ENTRIES = abta_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [abta_pkg::CMD_W-1:0]    req_command,
   input  logic [abta_pkg::KEY_W-1:0]    req_address_high,
   input  logic [abta_pkg::KEY_W-1:0]    req_address_low,
   input  logic [abta_pkg::LIFE_W-1:0]   req_lifetime_minutes,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [abta_pkg::STATUS_W-1:0] rsp_status,
   output logic [abta_pkg::KIND_W-1:0]   rsp_entry_kind,
   output logic [abta_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [abta_pkg::KEY_W-1:0]    rsp_key_high,
   output logic [abta_pkg::KEY_W-1:0]    rsp_key_low,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [abta_pkg::STALE_W-1:0]  csr_write_data
);
   import abta_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   fsm_type                   state_ff, state_in;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]          ev_idx_ff, ev_idx_in;
   cmd_type                   cmd_ff;
   logic [2*KEY_W-1:0]        addr_ff;
   logic [LIFE_W-1:0]         life_ff;
   logic [STALE_W-1:0]        stale_ff;
   logic [TABLE_ENTRIES-1:0]  valid_ff, valid_in;
   logic                      match_found_ff, match_found_in;
   logic [IDX_W-1:0]          match_idx_ff, match_idx_in;
   kind_type                  match_kind_ff, match_kind_in;
   logic                      free_found_ff, free_found_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [REPORT_CNT_W-1:0]   nrep_ff, nrep_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]          pend_idx_ff, pend_idx_in;
   logic [2*KEY_W-1:0]        pend_key_ff, pend_key_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff, rsp_in;

   logic                      req_accept;
   logic                      can_load;
   logic                      load;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic [2*KEY_W-1:0]        rd_key;
   meta_type                  rd_meta;
   logic [IDX_W-1:0]          wr_addr;
   logic                      key_we;
   logic                      meta_we;
   meta_type                  wr_meta;
   eval_type                  ev;

   assign req_stall  = (state_ff != FSM_IDLE);
   assign req_accept = req_valid && (state_ff == FSM_IDLE);
   assign can_load   = !rsp_valid_ff || !rsp_stall;

   abta_store #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_meta (rd_meta),
      .wr_addr (wr_addr),
      .key_we  (key_we),
      .wr_key  (addr_ff),
      .meta_we (meta_we),
      .wr_meta (wr_meta)
   );

   abta_eval u_eval (
      .is_tick       (cmd_ff == CMD_TICK),
      .entry_valid   (valid_ff[ev_idx_ff]),
      .search_key    (addr_ff),
      .entry_key     (rd_key),
      .entry_meta    (rd_meta),
      .stale_seconds (stale_ff),
      .reports_full  (nrep_ff == REPORT_CNT_W'(MAX_REPORTS)),
      .result        (ev)
   );

   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      ev_valid_in    = ev_valid_ff;
      ev_idx_in      = ev_idx_ff;
      valid_in       = valid_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_kind_in  = match_kind_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      nrep_in        = nrep_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      pend_key_in    = pend_key_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff[IDX_W-1:0];
      wr_addr        = ev_idx_ff;
      key_we         = 1'b0;
      meta_we        = 1'b0;
      wr_meta        = ev.meta;
      load           = 1'b0;
      rsp_in.status   = ST_OK;
      rsp_in.kind     = KIND_TENTATIVE;
      rsp_in.slot     = '0;
      rsp_in.key_high = addr_ff[2*KEY_W-1:KEY_W];
      rsp_in.key_low  = addr_ff[KEY_W-1:0];
      rsp_in.last     = 1'b1;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_accept && (req_command <= CMD_TICK)) begin
               state_in       = FSM_SCAN;
               rd_idx_in      = '0;
               ev_valid_in    = 1'b0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               nrep_in        = '0;
               pend_valid_in  = 1'b0;
            end
         end
         FSM_SCAN: begin
            if (!(ev_valid_ff && ev.report && pend_valid_ff && !can_load)) begin
               if (rd_idx_ff < CNT_W'(TABLE_ENTRIES)) begin
                  rd_en       = 1'b1;
                  rd_idx_in   = rd_idx_ff + CNT_W'(1);
                  ev_valid_in = 1'b1;
                  ev_idx_in   = rd_idx_ff[IDX_W-1:0];
               end else begin
                  ev_valid_in = 1'b0;
               end
               if (ev_valid_ff) begin
                  meta_we = ev.meta_we;
                  if (ev.clear_valid) begin
                     valid_in[ev_idx_ff] = 1'b0;
                  end
                  if (ev.match && !match_found_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = ev_idx_ff;
                     match_kind_in  = ev.meta.kind;
                  end
                  if (!valid_ff[ev_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = ev_idx_ff;
                  end
                  if (ev.report) begin
                     nrep_in       = nrep_ff + REPORT_CNT_W'(1);
                     pend_valid_in = 1'b1;
                     pend_idx_in   = ev_idx_ff;
                     pend_key_in   = rd_key;
                     if (pend_valid_ff) begin
                        load            = 1'b1;
                        rsp_in.status   = ST_EXPIRED;
                        rsp_in.kind     = KIND_STALE;
                        rsp_in.slot     = SLOT_W'(pend_idx_ff);
                        rsp_in.key_high = pend_key_ff[2*KEY_W-1:KEY_W];
                        rsp_in.key_low  = pend_key_ff[KEY_W-1:0];
                        rsp_in.last     = 1'b0;
                     end
                  end
               end
            end
            if ((rd_idx_ff == CNT_W'(TABLE_ENTRIES)) && !ev_valid_ff) begin
               state_in = (cmd_ff == CMD_TICK) ? FSM_FLUSH : FSM_APPLY;
            end
         end
         FSM_APPLY: begin
            if (can_load) begin
               load     = 1'b1;
               state_in = FSM_IDLE;
               wr_addr  = match_idx_ff;
               wr_meta.kind      = KIND_TENTATIVE;
               wr_meta.timer_on  = 1'b0;
               wr_meta.countdown = '0;
               if (cmd_ff == CMD_ADD) begin
                  if (match_found_ff) begin
                     rsp_in.status = ST_PRESENT;
                     rsp_in.kind   = match_kind_ff;
                     rsp_in.slot   = SLOT_W'(match_idx_ff);
                  end else if (free_found_ff) begin
                     rsp_in.slot           = SLOT_W'(free_idx_ff);
                     wr_addr               = free_idx_ff;
                     key_we                = 1'b1;
                     meta_we               = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end else if (!match_found_ff) begin
                  rsp_in.status = ST_NOT_FOUND;
               end else begin
                  rsp_in.slot = SLOT_W'(match_idx_ff);
                  rsp_in.kind = match_kind_ff;
                  priority case (cmd_ff)
                     CMD_REMOVE: begin
                        valid_in[match_idx_ff] = 1'b0;
                     end
                     CMD_MARK_TENTATIVE: begin
                        rsp_in.kind = KIND_TENTATIVE;
                        meta_we     = 1'b1;
                     end
                     CMD_MARK_REACHABLE: begin
                        rsp_in.kind       = KIND_REACHABLE;
                        meta_we           = 1'b1;
                        wr_meta.kind      = KIND_REACHABLE;
                        wr_meta.timer_on  = (life_ff != '0);
                        wr_meta.countdown =
                           COUNT_W'(32'(life_ff) * SECONDS_PER_MINUTE);
                     end
                     CMD_MARK_STALE: begin
                        rsp_in.kind       = KIND_STALE;
                        meta_we           = 1'b1;
                        wr_meta.kind      = KIND_STALE;
                        wr_meta.timer_on  = 1'b1;
                        wr_meta.countdown = COUNT_W'(stale_ff);
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         FSM_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = FSM_IDLE;
            end else if (can_load) begin
               load            = 1'b1;
               pend_valid_in   = 1'b0;
               state_in        = FSM_IDLE;
               rsp_in.status   = ST_EXPIRED;
               rsp_in.kind     = KIND_STALE;
               rsp_in.slot     = SLOT_W'(pend_idx_ff);
               rsp_in.key_high = pend_key_ff[2*KEY_W-1:KEY_W];
               rsp_in.key_low  = pend_key_ff[KEY_W-1:0];
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         ev_valid_ff   <= 1'b0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         stale_ff      <= STALE_RESET;
      end else begin
         state_ff      <= state_in;
         ev_valid_ff   <= ev_valid_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            stale_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      ev_idx_ff      <= ev_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_kind_ff  <= match_kind_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      nrep_ff        <= nrep_in;
      pend_idx_ff    <= pend_idx_in;
      pend_key_ff    <= pend_key_in;
      if (req_accept) begin
         cmd_ff  <= cmd_type'(req_command);
         addr_ff <= {req_address_high, req_address_low};
         life_ff <= req_lifetime_minutes;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_entry_kind = rsp_ff.kind;
   assign rsp_slot       = rsp_ff.slot;
   assign rsp_key_high   = rsp_ff.key_high;
   assign rsp_key_low    = rsp_ff.key_low;
   assign rsp_last       = rsp_ff.last;

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Address binding table with aging: self-checking testbench
// This testbench keeps its own copy of the table, the timers and the
// stale duration. For each request that the block accepts, it works out the
// replies due, and it checks every accepted reply against the oldest one
// due, field by field. A directed opening covers the empty and the full
// table, the extreme addresses and every command. Random requests then work
// on a small pool of addresses under several stale durations and several
// patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import abta_pkg::*;

   localparam int ENTRIES       = DEFAULT_ENTRIES;
   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
   localparam int POOL_SIZE     = 20;
   localparam int PHASE_ITEMS   = 8;
   localparam int EXPIRY_TICKS  = SECONDS_PER_MINUTE;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   class binding_table_mirror;
      bit                 occupied      [ENTRIES];
      logic [KEY_W-1:0]   held_high     [ENTRIES];
      logic [KEY_W-1:0]   held_low      [ENTRIES];
      kind_type           held_kind     [ENTRIES];
      bit                 timer_running [ENTRIES];
      logic [COUNT_W-1:0] remaining     [ENTRIES];
      logic [STALE_W-1:0] stale_span;
      rsp_type            awaited [$];
      int                 mismatches;

      function new();
         stale_span = STALE_RESET;
         mismatches = 0;
         foreach (occupied[i]) begin
            occupied[i]      = 1'b0;
            timer_running[i] = 1'b0;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void set_stale_span(logic [STALE_W-1:0] span);
         stale_span = span;
      endfunction

      function void enqueue(status_type st, kind_type kind, int slot,
                            logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo);
         rsp_type r;
         r.status   = st;
         r.kind     = kind;
         r.slot     = SLOT_W'(slot);
         r.key_high = hi;
         r.key_low  = lo;
         r.last     = 1'b1;
         awaited.push_back(r);
      endfunction

      function int find_entry(logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo);
         for (int i = 0; i < ENTRIES; i++) begin
            if (occupied[i] && held_high[i] == hi && held_low[i] == lo) begin
               return i;
            end
         end
         return -1;
      endfunction

      function void age_entries();
         int reports;
         reports = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!occupied[i] || !timer_running[i]) begin
               continue;
            end
            if (remaining[i] > 1) begin
               remaining[i] = remaining[i] - 1'b1;
            end else if (held_kind[i] == KIND_REACHABLE) begin
               held_kind[i] = KIND_STALE;
               remaining[i] = COUNT_W'(stale_span);
            end else if (held_kind[i] == KIND_STALE) begin
               if (reports < MAX_REPORTS) begin
                  if (reports > 0) begin
                     awaited[$].last = 1'b0;
                  end
                  enqueue(ST_EXPIRED, KIND_STALE, i, held_high[i], held_low[i]);
                  reports++;
                  occupied[i]      = 1'b0;
                  timer_running[i] = 1'b0;
               end else begin
                  remaining[i] = '0;
               end
            end else begin
               timer_running[i] = 1'b0;
            end
         end
      endfunction

      function void apply_request(logic [CMD_W-1:0] code, logic [KEY_W-1:0] hi,
                                  logic [KEY_W-1:0] lo, logic [LIFE_W-1:0] life);
         int       hit;
         kind_type kind;
         if (code == CMD_TICK) begin
            age_entries();
            return;
         end
         if (code > CMD_TICK) begin
            return;
         end
         hit = find_entry(hi, lo);
         if (code == CMD_ADD) begin
            if (hit >= 0) begin
               enqueue(ST_PRESENT, held_kind[hit], hit, hi, lo);
               return;
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (!occupied[i]) begin
                  occupied[i]      = 1'b1;
                  held_high[i]     = hi;
                  held_low[i]      = lo;
                  held_kind[i]     = KIND_TENTATIVE;
                  timer_running[i] = 1'b0;
                  remaining[i]     = '0;
                  enqueue(ST_OK, KIND_TENTATIVE, i, hi, lo);
                  return;
               end
            end
            enqueue(ST_FULL, KIND_TENTATIVE, 0, hi, lo);
            return;
         end
         if (hit < 0) begin
            enqueue(ST_NOT_FOUND, KIND_TENTATIVE, 0, hi, lo);
            return;
         end
         kind = held_kind[hit];
         case (code)
            CMD_REMOVE: begin
               occupied[hit]      = 1'b0;
               timer_running[hit] = 1'b0;
            end
            CMD_MARK_TENTATIVE: begin
               held_kind[hit]     = KIND_TENTATIVE;
               timer_running[hit] = 1'b0;
            end
            CMD_MARK_REACHABLE: begin
               held_kind[hit]     = KIND_REACHABLE;
               timer_running[hit] = (life != '0);
               remaining[hit]     = COUNT_W'(32'(life) * SECONDS_PER_MINUTE);
            end
            CMD_MARK_STALE: begin
               held_kind[hit]     = KIND_STALE;
               timer_running[hit] = 1'b1;
               remaining[hit]     = COUNT_W'(stale_span);
            end
            default: begin
            end
         endcase
         if (code != CMD_REMOVE) begin
            kind = held_kind[hit];
         end
         enqueue(ST_OK, kind, hit, held_high[hit], held_low[hit]);
      endfunction

      task report_mismatch(string text);
         $display("MISMATCH at %0t: %s", $realtime, text);
         mismatches++;
      endtask

      task compare_field(string name, logic [KEY_W-1:0] seen, logic [KEY_W-1:0] wanted);
         if (seen !== wanted) begin
            report_mismatch($sformatf("%s is %0h, awaited %0h", name, seen, wanted));
         end
      endtask

      task match_reply(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("reply with none awaited, status %0d slot %0d",
                                      got.status, got.slot));
            return;
         end
         want = awaited.pop_front();
         compare_field("status", KEY_W'(got.status), KEY_W'(want.status));
         compare_field("entry_kind", KEY_W'(got.kind), KEY_W'(want.kind));
         compare_field("slot", KEY_W'(got.slot), KEY_W'(want.slot));
         compare_field("key_high", got.key_high, want.key_high);
         compare_field("key_low", got.key_low, want.key_low);
         compare_field("last", KEY_W'(got.last), KEY_W'(want.last));
      endtask
   endclass

   logic                clock                = 1'b0;
   logic                reset                = 1'b1;
   logic                req_valid            = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command          = '0;
   logic [KEY_W-1:0]    req_address_high     = '0;
   logic [KEY_W-1:0]    req_address_low      = '0;
   logic [LIFE_W-1:0]   req_lifetime_minutes = '0;
   logic                rsp_valid;
   logic                rsp_stall            = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [KIND_W-1:0]   rsp_entry_kind;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [KEY_W-1:0]    rsp_key_high;
   logic [KEY_W-1:0]    rsp_key_low;
   logic                rsp_last;
   logic                csr_write_enable     = 1'b0;
   logic [STALE_W-1:0]  csr_write_data       = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   logic [KEY_W-1:0] pool_high [POOL_SIZE];
   logic [KEY_W-1:0] pool_low  [POOL_SIZE];
   logic [KEY_W-1:0] reserved_high;
   logic [KEY_W-1:0] reserved_low;

   binding_table_mirror mirror = new();

   address_binding_table_aging #(
      .TABLE_ENTRIES(ENTRIES)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_address_high    (req_address_high),
      .req_address_low     (req_address_low),
      .req_lifetime_minutes(req_lifetime_minutes),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_entry_kind      (rsp_entry_kind),
      .rsp_slot            (rsp_slot),
      .rsp_key_high        (rsp_key_high),
      .rsp_key_low         (rsp_key_low),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            mirror.match_reply('{status: status_type'(rsp_status),
                                 kind: kind_type'(rsp_entry_kind),
                                 slot: rsp_slot,
                                 key_high: rsp_key_high,
                                 key_low: rsp_key_low,
                                 last: rsp_last});
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic send_request(logic [CMD_W-1:0] code, logic [KEY_W-1:0] hi,
                               logic [KEY_W-1:0] lo, logic [LIFE_W-1:0] life);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_command          <= code;
      req_address_high     <= hi;
      req_address_low      <= lo;
      req_lifetime_minutes <= life;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      mirror.apply_request(code, hi, lo, life);
   endtask

   task automatic write_stale_span(logic [STALE_W-1:0] span);
      csr_write_enable <= 1'b1;
      csr_write_data   <= span;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror.set_stale_span(span);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (mirror.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic issue_random_request();
      int                pick;
      int                life_pick;
      int                which;
      logic [KEY_W-1:0]  hi;
      logic [KEY_W-1:0]  lo;
      logic [LIFE_W-1:0] life;
      cmd_type           code;
      pick      = $urandom_range(99);
      life_pick = $urandom_range(99);
      which     = $urandom_range(POOL_SIZE - 1);
      hi        = pool_high[which];
      lo        = pool_low[which];
      if ($urandom_range(9) == 0) begin
         hi = {$urandom, $urandom};
         lo = {$urandom, $urandom};
      end
      if (life_pick < 40) begin
         life = 16'd1;
      end else if (life_pick < 55) begin
         life = '0;
      end else if (life_pick < 65) begin
         life = '1;
      end else begin
         life = 16'($urandom);
      end
      if (pick < 3) begin
         send_request(CMD_UNUSED, hi, lo, life);
         return;
      end
      if (pick < 50) begin
         code = CMD_TICK;
      end else if (pick < 65) begin
         code = CMD_ADD;
      end else if (pick < 70) begin
         code = CMD_LOOKUP;
      end else if (pick < 76) begin
         code = CMD_REMOVE;
      end else if (pick < 81) begin
         code = CMD_MARK_TENTATIVE;
      end else if (pick < 91) begin
         code = CMD_MARK_REACHABLE;
      end else begin
         code = CMD_MARK_STALE;
      end
      send_request(code, hi, lo, life);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, logic [STALE_W-1:0] span);
      write_stale_span(span);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) issue_random_request();
      drain_replies();
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_high[i] = {$urandom, $urandom};
         pool_low[i]  = {$urandom, $urandom};
      end
      pool_high[14] = '0;
      pool_low[14]  = '0;
      pool_high[15] = '1;
      pool_low[15]  = '1;
      reserved_high = {$urandom, $urandom};
      reserved_low  = {$urandom, $urandom};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reserved entry gets a one-minute reachable timer, and a run of
      // ticks then takes it to stale and, with a one-second stale duration,
      // out of the table.
      write_stale_span(STALE_W'(1));
      send_request(CMD_TICK, '0, '0, '0);
      send_request(CMD_UNUSED, '1, '1, '1);
      send_request(CMD_LOOKUP, '1, '1, '0);
      send_request(CMD_MARK_STALE, pool_high[0], pool_low[0], '0);
      send_request(CMD_ADD, '0, '0, '0);
      send_request(CMD_ADD, '0, '0, '1);
      send_request(CMD_ADD, '1, '1, '0);
      send_request(CMD_ADD, reserved_high, reserved_low, '0);
      for (int i = 0; i < ENTRIES - 3; i++) begin
         send_request(CMD_ADD, pool_high[i], pool_low[i], 16'($urandom));
      end
      send_request(CMD_ADD, pool_high[ENTRIES - 3], pool_low[ENTRIES - 3], '0);
      send_request(CMD_MARK_REACHABLE, reserved_high, reserved_low, 16'd1);
      send_request(CMD_MARK_REACHABLE, '1, '1, '1);
      send_request(CMD_MARK_STALE, '0, '0, '0);
      send_request(CMD_TICK, '1, '1, '1);
      send_request(CMD_LOOKUP, '1, '1, '0);
      send_request(CMD_MARK_TENTATIVE, '1, '1, '0);
      send_request(CMD_REMOVE, '1, '1, '0);
      repeat (EXPIRY_TICKS) send_request(CMD_TICK, '0, '0, '0);
      drain_replies();

      run_phase(0, 0, STALE_W'(86400));
      run_phase(88, 0, STALE_W'(2));
      run_phase(0, 88, STALE_W'(1));
      run_phase(12, 12, STALE_W'(0));

      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("PASS address_binding_table_aging");
      end else begin
         $display("FAIL address_binding_table_aging");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL address_binding_table_aging");
      $finish;
   end

endmodule

@@ files.f @@
rtl/abta_pkg.sv
rtl/abta_store.sv
rtl/abta_eval.sv
rtl/address_binding_table_aging.sv
test/testbench.sv
